/* rtl/psc_pkg.sv */
// Shared widths, register indexes, codes and helpers for the PID steering correction block.
`default_nettype none
package psc_pkg;

  localparam int ERR_W      = 16;
  localparam int TIME_W     = 32;
  localparam int GAIN_W     = 16;
  localparam int LIM_W      = 15;
  localparam int PER_W      = 16;
  localparam int OUT_W      = 16;
  localparam int IN_DATA_W  = 48;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic signed [ERR_W-1:0]  sample_t;
  typedef logic signed [GAIN_W-1:0] gain_t;
  typedef logic        [LIM_W-1:0]  limit_t;
  typedef logic        [PER_W-1:0]  period_t;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_INTEG_LIMIT = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_CORR_LIMIT  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_PERIOD      = 3'd5;

  localparam gain_t   PROP_GAIN_RST   = 16'sd256;
  localparam gain_t   INTEG_GAIN_RST  = 16'sd0;
  localparam gain_t   DERIV_GAIN_RST  = 16'sd0;
  localparam limit_t  INTEG_LIMIT_RST = 15'd32767;
  localparam limit_t  CORR_LIMIT_RST  = 15'd32767;
  localparam period_t PERIOD_RST      = 16'd10;

  // input word kinds
  localparam logic KIND_UPDATE  = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  function automatic logic [ERR_W-1:0] mag16(input logic signed [ERR_W-1:0] v);
    mag16 = v[ERR_W-1] ? ERR_W'(-v) : ERR_W'(v);
  endfunction

  function automatic logic [ERR_W:0] mag17(input logic signed [ERR_W:0] v);
    mag17 = v[ERR_W] ? (ERR_W+1)'(-v) : (ERR_W+1)'(v);
  endfunction

  function automatic logic signed [34:0] clamp35(input logic signed [34:0] v,
                                                 input logic signed [34:0] lim);
    if (v > lim) begin
      clamp35 = lim;
    end else if (v < -lim) begin
      clamp35 = -lim;
    end else begin
      clamp35 = v;
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/pid_steering_correction.sv */
// PID steering correction: time-scaled PID terms over one multiplier and a restoring divider.
// A restart word goes straight to the final step. The first sample after reset or restart
// skips the derivative and both divisions. Later samples divide the integral product by the
// period and the derivative product by the elapsed time in the one-bit-per-cycle divider;
// a result still held at the output stalls the final step. The next word is taken
// while a result waits. Reset (rst_n low, synchronous) restores register defaults, clears state.
`default_nettype none
module pid_steering_correction #(
  parameter int GAIN_FRACTION_BITS = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [psc_pkg::IN_DATA_W-1:0]       in_tdata,   // error[15:0], time_ms[47:16]
  input  wire logic [0:0]                          in_tuser,   // kind[0]
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [psc_pkg::OUT_W-1:0]                out_tdata,  // correction[15:0]
  input  wire logic                                cfg_wr_en,
  input  wire logic [psc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire logic [psc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int F     = GAIN_FRACTION_BITS;
  localparam int QI    = 16 + F;  // integral quotient bits; larger saturates the clamp
  localparam int QD    = 31;      // derivative quotient bits; larger saturates the sum
  localparam int CNT_W = $clog2(QD + 1);
  localparam logic signed [34:0] RND_ADD = 35'((1 << F) - 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PROP  = 4'd1;
  localparam logic [3:0] ST_I1    = 4'd2;
  localparam logic [3:0] ST_I2    = 4'd3;
  localparam logic [3:0] ST_I3    = 4'd4;
  localparam logic [3:0] ST_I4    = 4'd5;
  localparam logic [3:0] ST_DLOAD = 4'd6;
  localparam logic [3:0] ST_DIV   = 4'd7;
  localparam logic [3:0] ST_IACC  = 4'd8;
  localparam logic [3:0] ST_D1    = 4'd9;
  localparam logic [3:0] ST_D2    = 4'd10;
  localparam logic [3:0] ST_D3    = 4'd11;
  localparam logic [3:0] ST_DACC  = 4'd12;
  localparam logic [3:0] ST_SUM   = 4'd13;
  localparam logic [3:0] ST_FIN   = 4'd14;

  // configuration
  psc_pkg::gain_t   kp_r, ki_r, kd_r;
  psc_pkg::limit_t  ilim_r, clim_r;
  psc_pkg::period_t period_r;

  // control and PID state
  logic [3:0]        state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  psc_pkg::sample_t  last_error_r, last_error_nxt;
  logic signed [31:0] integral_acc_r, integral_acc_nxt;
  logic [31:0]       last_time_r, last_time_nxt;
  logic              started_r, started_nxt;

  // datapath
  psc_pkg::sample_t  err_r, err_nxt;
  logic [31:0]       time_r, time_nxt;
  logic              kind_r, kind_nxt;
  logic [31:0]       el_r, el_nxt;
  logic signed [16:0] diff_r, diff_nxt;
  logic [48:0]       mul_r;
  logic signed [31:0] prop_r, prop_nxt;
  logic [31:0]       m1_r, m1_nxt;
  logic [47:0]       lo_r, lo_nxt;
  logic [63:0]       dvd_r, dvd_nxt;
  logic [31:0]       rem_r, rem_nxt;
  logic [63:0]       quo_r, quo_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              div_sel_r, div_sel_nxt;
  logic              ovf_r, ovf_nxt;
  logic signed [31:0] integ_r, integ_nxt;
  logic signed [32:0] deriv_r, deriv_nxt;
  logic signed [34:0] sum_r, sum_nxt;
  logic [15:0]       out_data_r, out_data_nxt;

  // combinational helpers
  logic [31:0]       mul_a;
  logic [16:0]       mul_b;
  logic [48:0]       mul_p;
  psc_pkg::period_t  periodv;
  psc_pkg::sample_t  in_err;
  logic [31:0]       in_time, dt;
  logic [31:0]       divisor;
  logic [63:0]       div_hi, div_init;
  logic              div_ovf;
  logic [32:0]       shifted;
  logic [33:0]       trial;
  logic              step_bit;
  logic [31:0]       q_val;
  logic signed [34:0] q35, ilimx, climx, m1s, inc35, clamped, rnd, res35;
  logic              fin_go;
  logic [3:0]        post_div;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign periodv = (period_r == '0) ? 16'd1 : period_r;
  assign in_err  = $signed(in_tdata[15:0]);
  assign in_time = in_tdata[47:16];
  assign dt      = in_time - last_time_r;

  assign mul_p = 49'(mul_a) * 49'(mul_b);

  // shared divider: integral divides by the period, derivative by the elapsed time
  assign divisor  = div_sel_r ? el_r : 32'(periodv);
  assign div_hi   = div_sel_r ? (dvd_r >> QD) : (dvd_r >> QI);
  assign div_init = div_sel_r ? (dvd_r << (64 - QD)) : (dvd_r << (64 - QI));
  assign div_ovf  = (div_hi >= 64'(divisor));
  assign post_div = div_sel_r ? ST_DACC : ST_IACC;
  assign shifted  = {rem_r, quo_r[63]};
  assign trial    = {1'b0, shifted} - {2'b0, divisor};
  assign step_bit = ~trial[33];

  assign q_val = ovf_r ? (div_sel_r ? (32'd1 << QD) : (32'd1 << QI)) : quo_r[31:0];
  assign q35   = $signed({3'b0, q_val});
  assign ilimx = $signed(35'(ilim_r) << F);
  assign climx = $signed(35'(clim_r) << F);
  assign m1s   = (ki_r[15] ^ err_r[15]) ? -$signed({3'b0, mul_r[31:0]})
                                        : $signed({3'b0, mul_r[31:0]});
  assign inc35 = (ki_r[15] ^ err_r[15]) ? -q35 : q35;

  assign clamped = psc_pkg::clamp35(sum_r, climx);
  assign rnd     = clamped[34] ? (clamped + RND_ADD) : clamped;
  assign res35   = rnd >>> F;
  assign fin_go  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt        = state_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    last_error_nxt   = last_error_r;
    integral_acc_nxt = integral_acc_r;
    last_time_nxt    = last_time_r;
    started_nxt      = started_r;
    err_nxt          = err_r;
    time_nxt         = time_r;
    kind_nxt         = kind_r;
    el_nxt           = el_r;
    diff_nxt         = diff_r;
    prop_nxt         = prop_r;
    m1_nxt           = m1_r;
    lo_nxt           = lo_r;
    dvd_nxt          = dvd_r;
    rem_nxt          = rem_r;
    quo_nxt          = quo_r;
    cnt_nxt          = cnt_r;
    div_sel_nxt      = div_sel_r;
    ovf_nxt          = ovf_r;
    integ_nxt        = integ_r;
    deriv_nxt        = deriv_r;
    sum_nxt          = sum_r;
    out_data_nxt     = out_data_r;
    mul_a            = '0;
    mul_b            = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          err_nxt   = in_err;
          time_nxt  = in_time;
          kind_nxt  = in_tuser[0];
          el_nxt    = (dt == '0) ? 32'(periodv) : dt;
          diff_nxt  = 17'(in_err) - 17'(last_error_r);
          state_nxt = (in_tuser[0] == psc_pkg::KIND_RESTART) ? ST_FIN : ST_PROP;
        end
      end
      ST_PROP: begin
        mul_a     = 32'(psc_pkg::mag16(err_r));
        mul_b     = 17'(psc_pkg::mag16(kp_r));
        state_nxt = ST_I1;
      end
      ST_I1: begin
        prop_nxt  = (kp_r[15] ^ err_r[15]) ? (32'd0 - mul_r[31:0]) : mul_r[31:0];
        mul_a     = 32'(psc_pkg::mag16(err_r));
        mul_b     = 17'(psc_pkg::mag16(ki_r));
        state_nxt = ST_I2;
      end
      ST_I2: begin
        m1_nxt = mul_r[31:0];
        if (!started_r) begin
          // first sample: plain ki*error, no derivative
          integ_nxt = 32'(psc_pkg::clamp35(m1s, ilimx));
          deriv_nxt = '0;
          state_nxt = ST_SUM;
        end else begin
          mul_a     = mul_r[31:0];
          mul_b     = {1'b0, el_r[15:0]};
          state_nxt = ST_I3;
        end
      end
      ST_I3: begin
        lo_nxt    = mul_r[47:0];
        mul_a     = m1_r;
        mul_b     = {1'b0, el_r[31:16]};
        state_nxt = ST_I4;
      end
      ST_I4: begin
        dvd_nxt     = 64'(lo_r) + (64'(mul_r[47:0]) << 16);
        div_sel_nxt = 1'b0;
        state_nxt   = ST_DLOAD;
      end
      ST_DLOAD: begin
        // quotient too wide for the counted bits: result saturates anyway
        rem_nxt   = div_hi[31:0];
        quo_nxt   = div_init;
        cnt_nxt   = div_sel_r ? CNT_W'(QD) : CNT_W'(QI);
        ovf_nxt   = div_ovf;
        state_nxt = div_ovf ? post_div : ST_DIV;
      end
      ST_DIV: begin
        rem_nxt = step_bit ? trial[31:0] : shifted[31:0];
        quo_nxt = {quo_r[62:0], step_bit};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = post_div;
        end
      end
      ST_IACC: begin
        integ_nxt = 32'(psc_pkg::clamp35(35'(integral_acc_r) + inc35, ilimx));
        state_nxt = ST_D1;
      end
      ST_D1: begin
        mul_a     = 32'(psc_pkg::mag17(diff_r));
        mul_b     = 17'(psc_pkg::mag16(kd_r));
        state_nxt = ST_D2;
      end
      ST_D2: begin
        mul_a     = mul_r[31:0];
        mul_b     = {1'b0, periodv};
        state_nxt = ST_D3;
      end
      ST_D3: begin
        dvd_nxt     = 64'(mul_r);
        div_sel_nxt = 1'b1;
        state_nxt   = ST_DLOAD;
      end
      ST_DACC: begin
        deriv_nxt = (kd_r[15] ^ diff_r[16]) ? -$signed({1'b0, q_val})
                                             : $signed({1'b0, q_val});
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        sum_nxt   = 35'(prop_r) + 35'(integ_r) + 35'(deriv_r);
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (fin_go) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (kind_r == psc_pkg::KIND_RESTART) begin
            out_data_nxt     = '0;
            last_error_nxt   = '0;
            integral_acc_nxt = '0;
            last_time_nxt    = '0;
            started_nxt      = 1'b0;
          end else begin
            out_data_nxt     = res35[15:0];
            last_error_nxt   = err_r;
            integral_acc_nxt = integ_r;
            last_time_nxt    = time_r;
            started_nxt      = 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
      last_error_r   <= '0;
      integral_acc_r <= '0;
      last_time_r    <= '0;
      started_r      <= 1'b0;
      kp_r           <= psc_pkg::PROP_GAIN_RST;
      ki_r           <= psc_pkg::INTEG_GAIN_RST;
      kd_r           <= psc_pkg::DERIV_GAIN_RST;
      ilim_r         <= psc_pkg::INTEG_LIMIT_RST;
      clim_r         <= psc_pkg::CORR_LIMIT_RST;
      period_r       <= psc_pkg::PERIOD_RST;
    end else begin
      state_r        <= state_nxt;
      out_valid_r    <= out_valid_nxt;
      last_error_r   <= last_error_nxt;
      integral_acc_r <= integral_acc_nxt;
      last_time_r    <= last_time_nxt;
      started_r      <= started_nxt;
      if (cfg_wr_en) begin
        case (cfg_addr)
          psc_pkg::REG_PROP_GAIN:   kp_r     <= $signed(cfg_wdata);
          psc_pkg::REG_INTEG_GAIN:  ki_r     <= $signed(cfg_wdata);
          psc_pkg::REG_DERIV_GAIN:  kd_r     <= $signed(cfg_wdata);
          psc_pkg::REG_INTEG_LIMIT: ilim_r   <= cfg_wdata[14:0];
          psc_pkg::REG_CORR_LIMIT:  clim_r   <= cfg_wdata[14:0];
          psc_pkg::REG_PERIOD:      period_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    err_r      <= err_nxt;
    time_r     <= time_nxt;
    kind_r     <= kind_nxt;
    el_r       <= el_nxt;
    diff_r     <= diff_nxt;
    mul_r      <= mul_p;
    prop_r     <= prop_nxt;
    m1_r       <= m1_nxt;
    lo_r       <= lo_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    div_sel_r  <= div_sel_nxt;
    ovf_r      <= ovf_nxt;
    integ_r    <= integ_nxt;
    deriv_r    <= deriv_nxt;
    sum_r      <= sum_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef NO_ASSERTIONS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < divisor))
    else $error("divider remainder not below divisor");

  a_div_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r != '0))
    else $error("divider running with zero count");

  a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_PROP || state_r == ST_FIN))
    else $error("accepted word did not start the sequence");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FIN))
    else $error("result raised outside final step");
`endif

endmodule
`default_nettype wire
